@@ hdl/rptg_pkg.sv @@
// ----------------------------------------------------------------------------
// rptg_pkg
// Shared constants and controller/datapath types for the run pattern source.
// ----------------------------------------------------------------------------
package rptg_pkg;

  localparam int unsigned WordW     = 32;
  localparam int unsigned NumWords  = 4;
  localparam int unsigned ModeW     = 2;
  localparam int unsigned RunW      = 16;
  localparam int unsigned ListW     = 20;
  localparam int unsigned BaseW     = 31;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 20;

  // Divider: radix-2 restoring remainder, DivBitsPerStep dividend bits per step
  localparam int unsigned DivBitsPerStep = 4;
  localparam int unsigned DivSteps       = WordW / DivBitsPerStep;
  localparam int unsigned CntW           = $clog2(DivSteps);

  localparam logic [WordW-1:0] Golden = 32'h9e37_79b9;
  localparam logic [WordW-1:0] Mix1   = 32'h85eb_ca6b;
  localparam logic [WordW-1:0] Mix2   = 32'hc2b2_ae35;

  localparam logic [ModeW-1:0]    ModeRandom  = 2'd0;
  localparam logic [ModeW-1:0]    ModeAscend  = 2'd1;
  localparam logic [ModeW-1:0]    ModeDescend = 2'd2;
  localparam logic [ModeW-1:0]    ModeMixed   = 2'd3;

  localparam logic [CfgIdxW-1:0]  RegMode    = 2'd0;
  localparam logic [CfgIdxW-1:0]  RegMaxRun  = 2'd1;
  localparam logic [CfgIdxW-1:0]  RegListLen = 2'd2;

  localparam logic [RunW-1:0]     MaxRunReset  = 16'd64;
  localparam logic [ListW-1:0]    ListLenReset = 20'd10000;

  localparam logic CmdSeed = 1'b0;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_SEED_ADD,
    OP_SEED_MUL1,
    OP_SEED_MUL2,
    OP_SEED_STORE,
    OP_CHECK,
    OP_DRAW_RANDOM,
    OP_DRAW_LEN,
    OP_DIV_STEP,
    OP_DRAW_BASE,
    OP_DRAW_DIR,
    OP_ELEMENT,
    OP_EMIT
  } op_e;

  typedef struct packed {
    op_e  op;
    logic load_seed;
  } cmd_t;

  typedef struct packed {
    logic new_run;
    logic mode_random;
    logic mode_mixed;
    logic out_free;
  } sts_t;

  typedef struct packed {
    logic [ModeW-1:0] mode;
    logic [RunW-1:0]  max_run;
    logic [ListW-1:0] list_len;
  } cfg_t;

endpackage

@@ hdl/rptg_in_if.sv @@
// ----------------------------------------------------------------------------
// rptg_in_if
// Request channel: command and seed word.
// ----------------------------------------------------------------------------
interface rptg_in_if;
  logic                           valid;
  logic                           ready;
  logic                           cmd;
  logic [rptg_pkg::WordW-1:0]     seed_value;

  modport source (output valid, output cmd, output seed_value, input ready);
  modport sink   (input valid, input cmd, input seed_value, output ready);
endinterface

@@ hdl/rptg_out_if.sv @@
// ----------------------------------------------------------------------------
// rptg_out_if
// Result channel: generated element with run and list markers.
// ----------------------------------------------------------------------------
interface rptg_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [rptg_pkg::WordW-1:0] element_value;
  logic                              run_start;
  logic                              last_element;

  modport source (output valid, output element_value, output run_start,
                  output last_element, input ready);
  modport sink   (input valid, input element_value, input run_start,
                  input last_element, output ready);
endinterface

@@ hdl/rptg_cfg_if.sv @@
// ----------------------------------------------------------------------------
// rptg_cfg_if
// Register write channel: register index and write data.
// ----------------------------------------------------------------------------
interface rptg_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [rptg_pkg::CfgIdxW-1:0]     index;
  logic [rptg_pkg::CfgDataW-1:0]    data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

@@ hdl/rptg_ctrl.sv @@
// ----------------------------------------------------------------------------
// rptg_ctrl
// Sequencer: walks the seeding rounds, run set-up and element emission.
// ----------------------------------------------------------------------------
module rptg_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  logic           in_cmd_i,
  output logic           in_ready_o,
  input  rptg_pkg::sts_t sts_i,
  output rptg_pkg::cmd_t cmd_o
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SEED_ADD,
    ST_SEED_MUL1,
    ST_SEED_MUL2,
    ST_SEED_STORE,
    ST_CHECK,
    ST_DRAW_RANDOM,
    ST_DRAW_LEN,
    ST_DIVIDE,
    ST_DRAW_BASE,
    ST_DRAW_DIR,
    ST_ELEMENT,
    ST_EMIT
  } state_e;

  state_e                    state_q;
  logic [rptg_pkg::CntW-1:0] cnt_q;
  logic                      take;

  assign in_ready_o = (state_q == ST_IDLE);
  assign take       = in_valid_i && in_ready_o;

  always_comb begin
    cmd_o.load_seed = take && (in_cmd_i == rptg_pkg::CmdSeed);
    case (state_q)
      ST_SEED_ADD:    cmd_o.op = rptg_pkg::OP_SEED_ADD;
      ST_SEED_MUL1:   cmd_o.op = rptg_pkg::OP_SEED_MUL1;
      ST_SEED_MUL2:   cmd_o.op = rptg_pkg::OP_SEED_MUL2;
      ST_SEED_STORE:  cmd_o.op = rptg_pkg::OP_SEED_STORE;
      ST_CHECK:       cmd_o.op = rptg_pkg::OP_CHECK;
      ST_DRAW_RANDOM: cmd_o.op = rptg_pkg::OP_DRAW_RANDOM;
      ST_DRAW_LEN:    cmd_o.op = rptg_pkg::OP_DRAW_LEN;
      ST_DIVIDE:      cmd_o.op = rptg_pkg::OP_DIV_STEP;
      ST_DRAW_BASE:   cmd_o.op = rptg_pkg::OP_DRAW_BASE;
      ST_DRAW_DIR:    cmd_o.op = rptg_pkg::OP_DRAW_DIR;
      ST_ELEMENT:     cmd_o.op = rptg_pkg::OP_ELEMENT;
      ST_EMIT:        cmd_o.op = sts_i.out_free ? rptg_pkg::OP_EMIT : rptg_pkg::OP_NONE;
      default:        cmd_o.op = rptg_pkg::OP_NONE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          cnt_q <= '0;
          if (take) begin
            state_q <= (in_cmd_i == rptg_pkg::CmdSeed) ? ST_SEED_ADD : ST_CHECK;
          end
        end
        ST_SEED_ADD:  state_q <= ST_SEED_MUL1;
        ST_SEED_MUL1: state_q <= ST_SEED_MUL2;
        ST_SEED_MUL2: state_q <= ST_SEED_STORE;
        ST_SEED_STORE: begin
          // one SplitMix round per generator word
          if (cnt_q == rptg_pkg::CntW'(rptg_pkg::NumWords - 1)) begin
            state_q <= ST_IDLE;
          end else begin
            cnt_q   <= cnt_q + 1'b1;
            state_q <= ST_SEED_ADD;
          end
        end
        ST_CHECK: begin
          if (sts_i.mode_random) begin
            state_q <= ST_DRAW_RANDOM;
          end else if (sts_i.new_run) begin
            state_q <= ST_DRAW_LEN;
          end else begin
            state_q <= ST_ELEMENT;
          end
        end
        ST_DRAW_RANDOM: state_q <= ST_EMIT;
        ST_DRAW_LEN: begin
          cnt_q   <= '0;
          state_q <= ST_DIVIDE;
        end
        ST_DIVIDE: begin
          if (cnt_q == rptg_pkg::CntW'(rptg_pkg::DivSteps - 1)) begin
            state_q <= ST_DRAW_BASE;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        ST_DRAW_BASE: state_q <= sts_i.mode_mixed ? ST_DRAW_DIR : ST_ELEMENT;
        ST_DRAW_DIR:  state_q <= ST_ELEMENT;
        ST_ELEMENT:   state_q <= ST_EMIT;
        ST_EMIT: begin
          if (sts_i.out_free) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // A request is only taken from idle, and the step after it is decided by its command
  a_take_branch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take |=> (state_q == ST_SEED_ADD) || (state_q == ST_CHECK))
    else $error("request taken without entering a sequence");

  a_div_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DRAW_LEN) |=> (state_q == ST_DIVIDE) && (cnt_q == '0))
    else $error("divider not started from step zero");

  a_seed_exit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SEED_STORE) && (cnt_q == rptg_pkg::CntW'(rptg_pkg::NumWords - 1))
    |=> in_ready_o)
    else $error("seeding did not finish after four rounds");

endmodule

@@ hdl/rptg_dp.sv @@
// ----------------------------------------------------------------------------
// rptg_dp
// Datapath: xoshiro128** state, SplitMix seeding, run-length divider,
// run bookkeeping and the result register.
// ----------------------------------------------------------------------------
module rptg_dp (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  rptg_pkg::cmd_t                    cmd_i,
  output rptg_pkg::sts_t                    sts_o,
  input  rptg_pkg::cfg_t                    cfg_i,
  input  logic [rptg_pkg::WordW-1:0]        seed_value_i,
  input  logic                              out_ready_i,
  output logic                              out_valid_o,
  output logic signed [rptg_pkg::WordW-1:0] element_value_o,
  output logic                              run_start_o,
  output logic                              last_element_o
);

  localparam int unsigned W = rptg_pkg::WordW;

  logic [W-1:0]                 words_q [rptg_pkg::NumWords];
  logic [rptg_pkg::ListW-1:0]   pos_q;
  logic [rptg_pkg::RunW-1:0]    run_rem_q, run_off_q, run_size_q;
  logic [rptg_pkg::BaseW-1:0]   run_base_q;
  logic                         run_asc_q;
  logic                         out_valid_q;

  logic [W-1:0]                 s_q, prod_q, dvd_q, elem_q;
  logic [rptg_pkg::RunW:0]      rem_q;
  logic                         start_q;

  logic [W-1:0]                 nxt [rptg_pkg::NumWords];
  logic [W-1:0]                 draw_res, m5, r7, t2, t3;
  logic [W-1:0]                 mul_a, mul_b, mul_p;
  logic [rptg_pkg::ListW-1:0]   len, rest, pos_inc;
  logic [rptg_pkg::RunW-1:0]    modv, rlen;
  logic [rptg_pkg::RunW:0]      div_r;
  logic [W-1:0]                 div_d;
  logic [W-1:0]                 elem_d;
  logic                         restart, last_d, out_free;

  assign len  = (cfg_i.list_len == '0) ? rptg_pkg::ListW'(1) : cfg_i.list_len;
  assign modv = (cfg_i.max_run == '0) ? rptg_pkg::RunW'(1) : cfg_i.max_run;
  assign restart  = (pos_q >= len);
  assign out_free = !out_valid_q || out_ready_i;

  assign sts_o.new_run     = restart || (run_rem_q == '0);
  assign sts_o.mode_random = (cfg_i.mode == rptg_pkg::ModeRandom);
  assign sts_o.mode_mixed  = (cfg_i.mode == rptg_pkg::ModeMixed);
  assign sts_o.out_free    = out_free;

  // xoshiro128** output and state advance; *5 and *9 are shift-adds
  always_comb begin
    m5       = words_q[1] + (words_q[1] << 2);
    r7       = {m5[W-8:0], m5[W-1:W-7]};
    draw_res = r7 + (r7 << 3);
    t2       = words_q[2] ^ words_q[0];
    t3       = words_q[3] ^ words_q[1];
    nxt[0]   = words_q[0] ^ t3;
    nxt[1]   = words_q[1] ^ t2;
    nxt[2]   = t2 ^ (words_q[1] << 9);
    nxt[3]   = {t3[W-12:0], t3[W-1:W-11]};
  end

  // single shared multiplier for both SplitMix mixing steps
  always_comb begin
    if (cmd_i.op == rptg_pkg::OP_SEED_MUL1) begin
      mul_a = s_q ^ (s_q >> 16);
      mul_b = rptg_pkg::Mix1;
    end else begin
      mul_a = prod_q ^ (prod_q >> 13);
      mul_b = rptg_pkg::Mix2;
    end
    mul_p = mul_a * mul_b;
  end

  // restoring division, DivBitsPerStep dividend bits per step
  always_comb begin
    div_r = rem_q;
    div_d = dvd_q;
    for (int i = 0; i < int'(rptg_pkg::DivBitsPerStep); i++) begin
      div_r = {div_r[rptg_pkg::RunW-1:0], div_d[W-1]};
      div_d = div_d << 1;
      if (div_r >= {1'b0, modv}) begin
        div_r = div_r - {1'b0, modv};
      end
    end
  end

  always_comb begin
    rest = len - pos_q;
    rlen = rptg_pkg::RunW'(rem_q) + 1'b1;
    if ({{(rptg_pkg::ListW - rptg_pkg::RunW){1'b0}}, rlen} > rest) begin
      rlen = rest[rptg_pkg::RunW-1:0];
    end
  end

  always_comb begin
    if (run_asc_q) begin
      elem_d = {1'b0, run_base_q} + W'(run_off_q);
    end else begin
      elem_d = {1'b0, run_base_q} + (W'(run_size_q) - W'(1) - W'(run_off_q));
    end
  end

  assign pos_inc = pos_q + 1'b1;
  assign last_d  = (pos_inc >= len);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < int'(rptg_pkg::NumWords); i++) begin
        words_q[i] <= '0;
      end
      pos_q       <= '0;
      run_rem_q   <= '0;
      run_off_q   <= '0;
      run_size_q  <= '0;
      run_base_q  <= '0;
      run_asc_q   <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.op == rptg_pkg::OP_EMIT) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cmd_i.load_seed) begin
        pos_q      <= '0;
        run_rem_q  <= '0;
        run_off_q  <= '0;
        run_size_q <= '0;
        run_base_q <= '0;
      end
      case (cmd_i.op)
        rptg_pkg::OP_SEED_STORE: begin
          // shift in so the first round ends up in word 0
          for (int i = 0; i < int'(rptg_pkg::NumWords) - 1; i++) begin
            words_q[i] <= words_q[i+1];
          end
          words_q[rptg_pkg::NumWords-1] <= prod_q ^ (prod_q >> 16);
        end
        rptg_pkg::OP_CHECK: begin
          if (restart) begin
            pos_q      <= '0;
            run_rem_q  <= '0;
            run_off_q  <= '0;
            run_size_q <= '0;
            run_base_q <= '0;
          end
        end
        rptg_pkg::OP_DRAW_RANDOM: begin
          words_q    <= nxt;
          run_rem_q  <= '0;
          run_off_q  <= '0;
          run_size_q <= '0;
        end
        rptg_pkg::OP_DRAW_LEN: words_q <= nxt;
        rptg_pkg::OP_DRAW_BASE: begin
          words_q    <= nxt;
          run_base_q <= draw_res[W-1:1];
          run_size_q <= rlen;
          run_rem_q  <= rlen;
          run_off_q  <= '0;
          if (cfg_i.mode == rptg_pkg::ModeAscend) begin
            run_asc_q <= 1'b1;
          end else if (cfg_i.mode == rptg_pkg::ModeDescend) begin
            run_asc_q <= 1'b0;
          end
        end
        rptg_pkg::OP_DRAW_DIR: begin
          words_q   <= nxt;
          run_asc_q <= draw_res[0];
        end
        rptg_pkg::OP_ELEMENT: begin
          run_off_q <= run_off_q + 1'b1;
          run_rem_q <= run_rem_q - 1'b1;
        end
        rptg_pkg::OP_EMIT: begin
          if (last_d) begin
            pos_q      <= '0;
            run_rem_q  <= '0;
            run_off_q  <= '0;
            run_size_q <= '0;
            run_base_q <= '0;
          end else begin
            pos_q <= pos_inc;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_seed) begin
      s_q <= seed_value_i;
    end
    case (cmd_i.op)
      rptg_pkg::OP_SEED_ADD:  s_q    <= s_q + rptg_pkg::Golden;
      rptg_pkg::OP_SEED_MUL1: prod_q <= mul_p;
      rptg_pkg::OP_SEED_MUL2: prod_q <= mul_p;
      rptg_pkg::OP_DRAW_RANDOM: begin
        elem_q  <= draw_res;
        start_q <= 1'b1;
      end
      rptg_pkg::OP_DRAW_LEN: begin
        dvd_q <= draw_res;
        rem_q <= '0;
      end
      rptg_pkg::OP_DIV_STEP: begin
        dvd_q <= div_d;
        rem_q <= div_r;
      end
      rptg_pkg::OP_ELEMENT: begin
        elem_q  <= elem_d;
        start_q <= (run_off_q == '0);
      end
      rptg_pkg::OP_EMIT: begin
        element_value_o <= elem_q;
        run_start_o     <= start_q;
        last_element_o  <= last_d;
      end
      default: ;
    endcase
  end

  assign out_valid_o = out_valid_q;

  // offset and remaining always add up to the run size
  a_run_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ({1'b0, run_rem_q} + {1'b0, run_off_q}) == {1'b0, run_size_q})
    else $error("run bookkeeping out of step");

  a_last_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == rptg_pkg::OP_EMIT) && last_d |=> (pos_q == '0) && (run_rem_q == '0))
    else $error("list not restarted after final element");

  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == rptg_pkg::OP_DIV_STEP) |=> (rem_q < {1'b0, modv}))
    else $error("divider remainder not reduced");

  a_out_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(cmd_i.op == rptg_pkg::OP_EMIT))
    else $error("result raised without an emit");

endmodule

@@ hdl/run_pattern_test_generator_unit.sv @@
// ----------------------------------------------------------------------------
// run_pattern_test_generator_unit
// xoshiro128** test-pattern source producing random values or runs.
// ----------------------------------------------------------------------------
//  channel | dir | handshake     | payload
//  in_i    | in  | valid / ready | cmd, seed_value
//  out_o   | out | valid / ready | element_value, run_start, last_element
//  cfg_i   | in  | valid / ready | index, data (always ready)
//
//  A seed request runs four SplitMix rounds: add, two multiplies, store.
//  A next request draws a random value or steps its run, then emits; opening
//  a run adds length draw, divider steps, base draw and (mixed) direction draw.
//  One request is in flight at a time; the result register lets the next
//  request be taken while a result waits. A stalled result holds the sequencer
//  at its emit step. Reset clears generator words, list and run state.
// ----------------------------------------------------------------------------
module run_pattern_test_generator_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  rptg_in_if.sink            in_i,
  rptg_out_if.source         out_o,
  rptg_cfg_if.sink           cfg_i
);

  rptg_pkg::cfg_t cfg_q;
  rptg_pkg::cmd_t cmd;
  rptg_pkg::sts_t sts;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mode     <= rptg_pkg::ModeRandom;
      cfg_q.max_run  <= rptg_pkg::MaxRunReset;
      cfg_q.list_len <= rptg_pkg::ListLenReset;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        rptg_pkg::RegMode:    cfg_q.mode     <= cfg_i.data[rptg_pkg::ModeW-1:0];
        rptg_pkg::RegMaxRun:  cfg_q.max_run  <= cfg_i.data[rptg_pkg::RunW-1:0];
        rptg_pkg::RegListLen: cfg_q.list_len <= cfg_i.data[rptg_pkg::ListW-1:0];
        default: ;
      endcase
    end
  end

  rptg_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_cmd_i   (in_i.cmd),
    .in_ready_o (in_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  rptg_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .cfg_i           (cfg_q),
    .seed_value_i    (in_i.seed_value),
    .out_ready_i     (out_o.ready),
    .out_valid_o     (out_o.valid),
    .element_value_o (out_o.element_value),
    .run_start_o     (out_o.run_start),
    .last_element_o  (out_o.last_element)
  );

endmodule

@@ bench/tb_run_pattern_test_generator_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_run_pattern_test_generator_unit
// Self-checking bench for the run pattern source. A driver feeds seed and
// next requests from a pending queue and writes the registers between
// phases. A monitor compares every element against a local xoshiro128**
// run generator under random back-pressure and one long receiver hold-off.
// ----------------------------------------------------------------------------
module tb_run_pattern_test_generator_unit;

  localparam logic                           CmdNext      = 1'b1;
  localparam logic [rptg_pkg::CfgIdxW-1:0]   RegSpare     = 2'd3;
  localparam int                             SettleCycles = 24;
  localparam int                             QuietTail    = 150;
  localparam int                             ItemTarget   = 1900;
  localparam int                             PressureAt   = 200;
  localparam int                             HoldCycles   = 150;
  localparam int                             IdleLimit    = 3000;
  localparam int                             TailCycles   = 32;

  typedef enum logic {ReqItem, ReqReg} req_kind_e;

  typedef struct {
    req_kind_e                       kind;
    logic                            cmd;
    logic [rptg_pkg::WordW-1:0]      seed;
    logic [rptg_pkg::CfgIdxW-1:0]    idx;
    logic [rptg_pkg::CfgDataW-1:0]   data;
  } req_t;

  typedef struct packed {
    logic [rptg_pkg::WordW-1:0] value;
    logic                       run_start;
    logic                       last_elem;
  } elem_t;

  logic clk_i;
  logic rst_ni;

  rptg_in_if  in_if ();
  rptg_out_if out_if ();
  rptg_cfg_if cfg_if ();

  run_pattern_test_generator_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  req_t  stim_q [$];
  elem_t elem_q [$];

  int errors       = 0;
  int n_queued     = 0;
  int n_requests   = 0;
  int n_seeds      = 0;
  int n_results    = 0;
  int n_list_ends  = 0;
  int n_reg_writes = 0;
  int runs_opened  = 0;
  int settle_cnt   = 0;
  int gap_left     = 0;
  int stall_left   = 0;
  int hold_left    = 0;
  int idle_cycles  = 0;
  bit hold_done    = 1'b0;

  // local copy of generator, list and run state
  logic [rptg_pkg::WordW-1:0] gen_w [rptg_pkg::NumWords];
  logic [rptg_pkg::ListW-1:0] list_pos;
  logic [rptg_pkg::RunW-1:0]  run_left;
  logic [rptg_pkg::RunW-1:0]  run_off;
  logic [rptg_pkg::RunW-1:0]  run_len;
  logic [rptg_pkg::BaseW-1:0] run_base;
  logic                       run_up;
  logic [rptg_pkg::ModeW-1:0] cur_mode;
  logic [rptg_pkg::RunW-1:0]  cur_max_run;
  logic [rptg_pkg::ListW-1:0] cur_list_len;

  always #4 clk_i = ~clk_i;

  function automatic logic [rptg_pkg::WordW-1:0] rotl(logic [rptg_pkg::WordW-1:0] x,
                                                      int unsigned k);
    return (x << k) | (x >> (rptg_pkg::WordW - k));
  endfunction

  function automatic logic [rptg_pkg::WordW-1:0] xo_draw();
    logic [rptg_pkg::WordW-1:0] res;
    logic [rptg_pkg::WordW-1:0] sh;
    res = rotl(gen_w[1] * 32'd5, 7) * 32'd9;
    sh  = gen_w[1] << 9;
    gen_w[2] = gen_w[2] ^ gen_w[0];
    gen_w[3] = gen_w[3] ^ gen_w[1];
    gen_w[1] = gen_w[1] ^ gen_w[2];
    gen_w[0] = gen_w[0] ^ gen_w[3];
    gen_w[2] = gen_w[2] ^ sh;
    gen_w[3] = rotl(gen_w[3], 11);
    return res;
  endfunction

  function automatic void splitmix_fill(logic [rptg_pkg::WordW-1:0] s);
    logic [rptg_pkg::WordW-1:0] acc;
    logic [rptg_pkg::WordW-1:0] z;
    acc = s;
    for (int w = 0; w < rptg_pkg::NumWords; w++) begin
      acc = acc + rptg_pkg::Golden;
      z = acc;
      z = (z ^ (z >> 16)) * rptg_pkg::Mix1;
      z = (z ^ (z >> 13)) * rptg_pkg::Mix2;
      gen_w[w] = z ^ (z >> 16);
    end
  endfunction

  function automatic void clear_list();
    list_pos = '0;
    run_left = '0;
    run_off  = '0;
    run_len  = '0;
    run_base = '0;
  endfunction

  function automatic void write_reg(logic [rptg_pkg::CfgIdxW-1:0] idx,
                                    logic [rptg_pkg::CfgDataW-1:0] data);
    case (idx)
      rptg_pkg::RegMode:    cur_mode     = data[rptg_pkg::ModeW-1:0];
      rptg_pkg::RegMaxRun:  cur_max_run  = data[rptg_pkg::RunW-1:0];
      rptg_pkg::RegListLen: cur_list_len = data[rptg_pkg::ListW-1:0];
      default: ;
    endcase
  endfunction

  // Returns 1 when the request yields an element
  function automatic bit next_element(logic cmd, logic [rptg_pkg::WordW-1:0] seed,
                                      output elem_t el);
    logic [rptg_pkg::ListW-1:0] len;
    logic [rptg_pkg::WordW-1:0] modv;
    logic [rptg_pkg::WordW-1:0] rlen;
    logic [rptg_pkg::WordW-1:0] rest;
    logic [rptg_pkg::WordW-1:0] val;
    el  = '0;
    len = (cur_list_len == '0) ? 20'd1 : cur_list_len;
    if (cmd == rptg_pkg::CmdSeed) begin
      splitmix_fill(seed);
      clear_list();
      return 1'b0;
    end
    if (list_pos >= len) clear_list();
    if (cur_mode == rptg_pkg::ModeRandom) begin
      val = xo_draw();
      el.run_start = 1'b1;
      run_left = '0;
      run_off  = '0;
      run_len  = '0;
    end else begin
      if (run_left == '0) begin
        modv = (cur_max_run == '0) ? 32'd1 : {16'd0, cur_max_run};
        rlen = 32'd1 + xo_draw() % modv;
        rest = {12'd0, len} - {12'd0, list_pos};
        if (rlen > rest) rlen = rest;
        run_base = rptg_pkg::BaseW'(xo_draw() >> 1);
        if (cur_mode == rptg_pkg::ModeAscend) run_up = 1'b1;
        else if (cur_mode == rptg_pkg::ModeDescend) run_up = 1'b0;
        else run_up = 1'(xo_draw() & 32'd1);
        run_len  = rlen[rptg_pkg::RunW-1:0];
        run_left = rlen[rptg_pkg::RunW-1:0];
        run_off  = '0;
        runs_opened++;
      end
      el.run_start = (run_off == '0);
      if (run_up) val = {1'b0, run_base} + {16'd0, run_off};
      else val = {1'b0, run_base} + ({16'd0, run_len} - 32'd1 - {16'd0, run_off});
      run_off  = run_off + 16'd1;
      run_left = run_left - 16'd1;
    end
    list_pos = list_pos + 20'd1;
    el.last_elem = (list_pos >= len);
    if (el.last_elem) clear_list();
    el.value = val;
    return 1'b1;
  endfunction

  task automatic note_mismatch(string what, logic [rptg_pkg::WordW-1:0] got,
                               logic [rptg_pkg::WordW-1:0] want);
    errors++;
    if (errors <= 40)
      $display("[%0t] mismatch %s: got %h expected %h", $time, what, got, want);
  endtask

  function automatic void push_req(logic cmd, logic [rptg_pkg::WordW-1:0] seed);
    req_t r;
    r.kind = ReqItem;
    r.cmd  = cmd;
    r.seed = seed;
    r.idx  = '0;
    r.data = '0;
    stim_q.push_back(r);
    n_queued++;
  endfunction

  function automatic void push_next(int n);
    for (int i = 0; i < n; i++) push_req(CmdNext, $urandom);
  endfunction

  function automatic void push_reg(logic [rptg_pkg::CfgIdxW-1:0] idx,
                                   logic [rptg_pkg::CfgDataW-1:0] data);
    req_t r;
    r.kind = ReqReg;
    r.cmd  = rptg_pkg::CmdSeed;
    r.seed = '0;
    r.idx  = idx;
    r.data = data;
    stim_q.push_back(r);
  endfunction

  function automatic logic [rptg_pkg::WordW-1:0] pick_seed();
    case ($urandom_range(0, 7))
      0:       return 32'h0000_0000;
      1:       return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  // Driver: request and register write channels
  always @(posedge clk_i) begin : drive_proc
    req_t  head;
    elem_t want;
    logic  n_in_valid;
    logic  n_cfg_valid;
    if (rst_ni) begin
      n_in_valid  = in_if.valid;
      n_cfg_valid = cfg_if.valid;
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) settle_cnt = 0;
      else if (settle_cnt < SettleCycles) settle_cnt++;
      if (in_if.valid && in_if.ready) begin
        n_in_valid = 1'b0;
        n_requests++;
        if (in_if.cmd == rptg_pkg::CmdSeed) n_seeds++;
        if (next_element(in_if.cmd, in_if.seed_value, want)) elem_q.push_back(want);
        if (stim_q.size() > QuietTail && $urandom_range(0, 4) == 0)
          gap_left = $urandom_range(1, 7);
      end
      if (cfg_if.valid && cfg_if.ready) begin
        n_cfg_valid = 1'b0;
        n_reg_writes++;
        write_reg(cfg_if.index, cfg_if.data);
      end
      if (!n_in_valid && !n_cfg_valid && stim_q.size() > 0) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (stim_q[0].kind == ReqReg) begin
          // registers only change once the block has gone quiet
          if (elem_q.size() == 0 && settle_cnt >= SettleCycles) begin
            head = stim_q.pop_front();
            cfg_if.index <= head.idx;
            cfg_if.data  <= head.data;
            n_cfg_valid = 1'b1;
          end
        end else begin
          head = stim_q.pop_front();
          in_if.cmd        <= head.cmd;
          in_if.seed_value <= head.seed;
          n_in_valid = 1'b1;
        end
      end
      in_if.valid  <= n_in_valid;
      cfg_if.valid <= n_cfg_valid;
    end
  end

  // Monitor: result channel, checks and back-pressure
  always @(posedge clk_i) begin : watch_proc
    elem_t want;
    logic  n_ready;
    if (rst_ni) begin
      if (out_if.valid && out_if.ready) begin
        n_results++;
        if (out_if.last_element === 1'b1) n_list_ends++;
        if (elem_q.size() == 0) begin
          note_mismatch("unexpected result", out_if.element_value, '0);
        end else begin
          want = elem_q.pop_front();
          if ($unsigned(out_if.element_value) !== want.value)
            note_mismatch("element_value", out_if.element_value, want.value);
          if (out_if.run_start !== want.run_start)
            note_mismatch("run_start", {31'd0, out_if.run_start}, {31'd0, want.run_start});
          if (out_if.last_element !== want.last_elem)
            note_mismatch("last_element", {31'd0, out_if.last_element}, {31'd0, want.last_elem});
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        n_ready = 1'b0;
      end else if (!hold_done && n_results >= PressureAt) begin
        // long hold-off: the sender keeps offering, so the block backs up
        hold_done = 1'b1;
        hold_left = HoldCycles - 1;
        n_ready = 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        n_ready = 1'b0;
      end else if (stim_q.size() > QuietTail && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 7) - 1;
        n_ready = 1'b0;
      end else begin
        n_ready = 1'b1;
      end
      out_if.ready <= n_ready;
    end
  end

  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (cfg_if.valid && cfg_if.ready))
      idle_cycles = 0;
    else
      idle_cycles++;
  end

  initial begin : main_proc
    logic [rptg_pkg::ModeW-1:0]    mode;
    logic [rptg_pkg::CfgDataW-1:0] data;
    int                            count;
    clk_i = 1'b0;
    rst_ni = 1'b0;
    in_if.valid = 1'b0;
    in_if.cmd = rptg_pkg::CmdSeed;
    in_if.seed_value = '0;
    out_if.ready = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.index = rptg_pkg::RegMode;
    cfg_if.data = '0;
    gen_w[0] = '0;
    gen_w[1] = '0;
    gen_w[2] = '0;
    gen_w[3] = '0;
    clear_list();
    run_up = 1'b1;
    cur_mode = rptg_pkg::ModeRandom;
    cur_max_run = rptg_pkg::MaxRunReset;
    cur_list_len = rptg_pkg::ListLenReset;

    // unseeded generator, random mode then run mode
    push_next(2);
    push_reg(rptg_pkg::RegMode, {18'd0, rptg_pkg::ModeAscend});
    push_next(2);
    // seed extremes
    push_req(rptg_pkg::CmdSeed, 32'h0000_0000);
    push_next(1);
    push_req(rptg_pkg::CmdSeed, 32'hffff_ffff);
    push_next(2);
    // zero run length and zero list length both act as one
    push_reg(rptg_pkg::RegMode, {18'd0, rptg_pkg::ModeDescend});
    push_reg(rptg_pkg::RegMaxRun, 20'd0);
    push_reg(rptg_pkg::RegListLen, 20'd0);
    push_next(2);
    // mixed mode, widest run limit, list of five wraps round
    push_reg(rptg_pkg::RegMode, 20'hfffff);
    push_reg(rptg_pkg::RegMaxRun, 20'hfffff);
    push_reg(rptg_pkg::RegListLen, 20'd5);
    push_reg(RegSpare, 20'hfffff);
    push_req(rptg_pkg::CmdSeed, $urandom);
    push_next(6);
    // mode change mid-run, then list shortened under the position
    push_reg(rptg_pkg::RegMaxRun, 20'd8);
    push_reg(rptg_pkg::RegListLen, 20'd20);
    push_reg(rptg_pkg::RegMode, {18'd0, rptg_pkg::ModeAscend});
    push_req(rptg_pkg::CmdSeed, $urandom);
    push_next(3);
    push_reg(rptg_pkg::RegMode, {18'd0, rptg_pkg::ModeDescend});
    push_next(2);
    push_reg(rptg_pkg::RegListLen, 20'd2);
    push_next(1);
    push_reg(rptg_pkg::RegMode, {18'd0, rptg_pkg::ModeRandom});
    push_next(1);
    push_reg(rptg_pkg::RegListLen, 20'hfffff);
    push_reg(rptg_pkg::RegMode, {18'd0, rptg_pkg::ModeMixed});
    push_next(2);

    // random phases: mostly seeded next streams, some reseeds mid-list
    while (n_queued < ItemTarget) begin
      mode = rptg_pkg::ModeW'($urandom_range(0, 3));
      if ($urandom_range(0, 2) != 0) begin
        data = {18'd0, mode};
        if ($urandom_range(0, 3) == 0)
          data = rptg_pkg::CfgDataW'($urandom & 20'hffffc) | {18'd0, mode};
        push_reg(rptg_pkg::RegMode, data);
      end
      if ($urandom_range(0, 2) != 0) begin
        case ($urandom_range(0, 9))
          0:       data = 20'd0;
          1:       data = 20'h0ffff;
          2:       data = rptg_pkg::CfgDataW'($urandom & 20'hfffff);
          default: data = rptg_pkg::CfgDataW'($urandom_range(1, 12));
        endcase
        push_reg(rptg_pkg::RegMaxRun, data);
      end
      if ($urandom_range(0, 2) != 0) begin
        case ($urandom_range(0, 11))
          0:       data = 20'd0;
          1:       data = 20'd1;
          2:       data = 20'hfffff;
          3:       data = rptg_pkg::CfgDataW'($urandom & 20'hfffff);
          default: data = rptg_pkg::CfgDataW'($urandom_range(2, 48));
        endcase
        push_reg(rptg_pkg::RegListLen, data);
      end
      if ($urandom_range(0, 15) == 0)
        push_reg(RegSpare, rptg_pkg::CfgDataW'($urandom & 20'hfffff));
      if ($urandom_range(0, 1) == 0) push_req(rptg_pkg::CmdSeed, pick_seed());
      count = $urandom_range(20, 80);
      for (int i = 0; i < count; i++) begin
        if ($urandom_range(0, 29) == 0) push_req(rptg_pkg::CmdSeed, pick_seed());
        else push_req(CmdNext, $urandom);
      end
    end

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (!(stim_q.size() == 0 && !in_if.valid && !cfg_if.valid && elem_q.size() == 0) &&
           idle_cycles < IdleLimit)
      @(posedge clk_i);

    if (idle_cycles >= IdleLimit) begin
      $display("[%0t] timeout: %0d requests left, %0d elements outstanding", $time,
               stim_q.size(), elem_q.size());
      $display("CHECK FAILED");
      $finish;
    end else begin
      repeat (TailCycles) @(posedge clk_i);
      if (elem_q.size() != 0) note_mismatch("elements never produced", elem_q.size(), '0);
      $display("Covered %0d requests (%0d seeds) and %0d register writes.", n_requests,
               n_seeds, n_reg_writes);
      $display("Checked %0d elements: %0d runs opened, %0d list ends, %0d mismatches.",
               n_results, runs_opened, n_list_ends, errors);
      if (errors == 0)
        $display("CHECK OK");
      else
        $display("CHECK FAILED");
      $finish;
    end
  end

endmodule

@@ files.f @@
hdl/rptg_pkg.sv
hdl/rptg_in_if.sv
hdl/rptg_out_if.sv
hdl/rptg_cfg_if.sv
hdl/rptg_ctrl.sv
hdl/rptg_dp.sv
hdl/run_pattern_test_generator_unit.sv
bench/tb_run_pattern_test_generator_unit.sv
